// File: hw/rtl/asre_pkg.sv
`default_nettype none

package asre_pkg;

    // Input kinds carried on the slave-side tuser.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_LAYOUT_ONE     = 3'd0;
    localparam logic [2:0] REG_LAYOUT_TWO     = 3'd1;
    localparam logic [2:0] REG_LAYOUT_THREE   = 3'd2;
    localparam logic [2:0] REG_LAYOUT_FOUR    = 3'd3;
    localparam logic [2:0] REG_IDLE_RATE      = 3'd4;
    localparam logic [2:0] REG_HOME_EMULATION = 3'd5;
    localparam logic [2:0] REG_BONUS_BUTTONS  = 3'd6;

    localparam int unsigned NUM_LAYOUTS = 4;
    localparam int unsigned LAYOUT_W    = 24;
    localparam int unsigned PRESSED_W   = 15;
    localparam int unsigned REPORT_W    = 32;
    localparam int unsigned CONS_W      = 2;

    localparam logic [7:0] IDLE_MAX = 8'd255;

    // Stick button bit positions in the pressed vector.
    localparam int unsigned BTN_UP     = 0;
    localparam int unsigned BTN_DOWN   = 1;
    localparam int unsigned BTN_LEFT   = 2;
    localparam int unsigned BTN_RIGHT  = 3;
    localparam int unsigned BTN_LK     = 4;
    localparam int unsigned BTN_MK     = 5;
    localparam int unsigned BTN_4K     = 7;
    localparam int unsigned BTN_LP     = 8;
    localparam int unsigned BTN_MP     = 9;
    localparam int unsigned BTN_4P     = 11;
    localparam int unsigned BTN_START  = 12;
    localparam int unsigned BTN_SELECT = 13;
    localparam int unsigned BTN_HOME   = 14;

    // Keyboard report bit positions.
    localparam logic [4:0] KEY_UP     = 5'd0;
    localparam logic [4:0] KEY_RIGHT  = 5'd1;
    localparam logic [4:0] KEY_DOWN   = 5'd2;
    localparam logic [4:0] KEY_LEFT   = 5'd3;
    localparam logic [4:0] KEY_LCTRL  = 5'd4;
    localparam logic [4:0] KEY_LALT   = 5'd5;
    localparam logic [4:0] KEY_LSHIFT = 5'd6;
    localparam logic [4:0] KEY_ENTER  = 5'd7;
    localparam logic [4:0] KEY_ESCAPE = 5'd8;
    localparam logic [4:0] KEY_SPACE  = 5'd9;
    localparam logic [4:0] KEY_TAB    = 5'd10;
    localparam logic [4:0] KEY_F2     = 5'd11;
    localparam logic [4:0] KEY_F3     = 5'd12;
    localparam logic [4:0] KEY_A      = 5'd13;
    localparam logic [4:0] KEY_D      = 5'd14;
    localparam logic [4:0] KEY_F      = 5'd15;
    localparam logic [4:0] KEY_G      = 5'd16;
    localparam logic [4:0] KEY_I      = 5'd17;
    localparam logic [4:0] KEY_K      = 5'd18;
    localparam logic [4:0] KEY_P      = 5'd19;
    localparam logic [4:0] KEY_Q      = 5'd20;
    localparam logic [4:0] KEY_R      = 5'd21;
    localparam logic [4:0] KEY_S      = 5'd22;
    localparam logic [4:0] KEY_W      = 5'd23;
    localparam logic [4:0] KEY_X      = 5'd24;
    localparam logic [4:0] KEY_Y      = 5'd25;
    localparam logic [4:0] KEY_1      = 5'd26;
    localparam logic [4:0] KEY_2      = 5'd27;
    localparam logic [4:0] KEY_5      = 5'd28;
    localparam logic [4:0] KEY_6      = 5'd29;
    localparam logic [4:0] KEY_9      = 5'd30;

    localparam int unsigned CONS_VOL_UP   = 0;
    localparam int unsigned CONS_VOL_DOWN = 1;

    // Codes six and seven of a layout entry both mean an unmapped button.
    localparam logic [2:0] MAP_FIRST_NONE = 3'd6;

    typedef struct packed {
        logic [NUM_LAYOUTS-1:0][LAYOUT_W-1:0] layout_map;
        logic [7:0]                           idle_rate;
        logic                                 home_emulation;
        logic                                 bonus_buttons;
    } asre_cfg_t;

    typedef struct packed {
        logic                meta_held_before;
        logic                meta_consumed;
        logic                control_mode;
        logic                second_player;
        logic [1:0]          layout_select;
        logic [REPORT_W-1:0] last_report;
        logic [7:0]          idle_count;
    } asre_state_t;

    // Key for player button one to six.
    function automatic logic [4:0] asre_player_key(input logic [2:0] code,
                                                   input logic       player_two);
        logic [4:0] key;
        case (code)
            3'd0:    key = player_two ? KEY_A : KEY_LCTRL;
            3'd1:    key = player_two ? KEY_S : KEY_LALT;
            3'd2:    key = player_two ? KEY_Q : KEY_SPACE;
            3'd3:    key = player_two ? KEY_W : KEY_LSHIFT;
            3'd4:    key = player_two ? KEY_K : KEY_X;
            3'd5:    key = player_two ? KEY_I : KEY_Y;
            default: key = KEY_UP;
        endcase
        return key;
    endfunction

    // Eight attack buttons through the selected layout.
    function automatic logic [REPORT_W-1:0] asre_map_buttons(
        input logic [PRESSED_W-1:0] p,
        input logic [LAYOUT_W-1:0]  map,
        input logic                 extra,
        input logic                 player_two);
        logic [REPORT_W-1:0] r;
        logic [2:0]          code;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            code = map[3*i +: 3];
            if (((i != 3 && i != 7) || extra) && p[BTN_LK + i] && code < MAP_FIRST_NONE)
            begin
                r[asre_player_key(code, player_two)] = 1'b1;
            end
        end
        return r;
    endfunction

    // Stick directions; up wins over down and left wins over right.
    function automatic logic [REPORT_W-1:0] asre_directions(
        input logic [PRESSED_W-1:0] p,
        input logic [4:0]           k_up,
        input logic [4:0]           k_down,
        input logic [4:0]           k_left,
        input logic [4:0]           k_right);
        logic [REPORT_W-1:0] r;
        r = '0;
        if (p[BTN_UP])
        begin
            r[k_up] = 1'b1;
        end
        else if (p[BTN_DOWN])
        begin
            r[k_down] = 1'b1;
        end
        if (p[BTN_LEFT])
        begin
            r[k_left] = 1'b1;
        end
        else if (p[BTN_RIGHT])
        begin
            r[k_right] = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/asre_cfg_regs.sv
`default_nettype none

module asre_cfg_regs
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [23:0]         cfg_data,
    output asre_pkg::asre_cfg_t      cfg
);
    import asre_pkg::*;

    asre_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layout_map     <= '1;
            cfg_reg.idle_rate      <= '0;
            cfg_reg.home_emulation <= 1'b0;
            cfg_reg.bonus_buttons  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LAYOUT_ONE, REG_LAYOUT_TWO, REG_LAYOUT_THREE, REG_LAYOUT_FOUR:
                    cfg_reg.layout_map[cfg_index[1:0]] <= cfg_data;
                REG_IDLE_RATE:      cfg_reg.idle_rate      <= cfg_data[7:0];
                REG_HOME_EMULATION: cfg_reg.home_emulation <= cfg_data[0];
                REG_BONUS_BUTTONS:  cfg_reg.bonus_buttons  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hw/rtl/asre_encoder.sv
`default_nettype none

module asre_encoder
(
    input  wire logic                         kind,
    input  wire logic [14:0]                  pressed,
    input  wire asre_pkg::asre_cfg_t          cfg,
    input  wire asre_pkg::asre_state_t        state,
    output asre_pkg::asre_state_t             state_next,
    output logic                              send_keyboard,
    output logic [31:0]                       keyboard_report,
    output logic                              send_consumer,
    output logic [1:0]                        consumer_report
);
    import asre_pkg::*;

    always_comb
    begin
        asre_state_t         s;
        logic                meta;
        logic                released;
        logic [REPORT_W-1:0] kb;
        logic [CONS_W-1:0]   cons;
        logic                send;
        logic [LAYOUT_W-1:0] map;

        s        = state;
        meta     = pressed[BTN_START];
        released = 1'b0;
        kb       = '0;
        cons     = '0;
        send     = 1'b0;
        map      = cfg.layout_map[state.layout_select];

        if (kind == KIND_TICK)
        begin
            if (s.idle_count != IDLE_MAX)
            begin
                s.idle_count = s.idle_count + 8'd1;
            end
        end
        else
        begin
            // Meta combinations set layout, mode or player and mark meta used.
            if (meta)
            begin
                s.meta_held_before = 1'b1;
                if (pressed[BTN_LP])
                begin
                    if (pressed[BTN_UP])
                    begin
                        s.layout_select = 2'd0;
                        s.meta_consumed = 1'b1;
                    end
                    else if (pressed[BTN_RIGHT])
                    begin
                        s.layout_select = 2'd1;
                        s.meta_consumed = 1'b1;
                    end
                    else if (pressed[BTN_DOWN])
                    begin
                        s.layout_select = 2'd2;
                        s.meta_consumed = 1'b1;
                    end
                    else if (pressed[BTN_LEFT])
                    begin
                        s.layout_select = 2'd3;
                        s.meta_consumed = 1'b1;
                    end
                end
                else if (pressed[BTN_UP])
                begin
                    s.control_mode  = 1'b0;
                    s.meta_consumed = 1'b1;
                end
                else if (pressed[BTN_DOWN])
                begin
                    s.control_mode  = 1'b1;
                    s.meta_consumed = 1'b1;
                end
                if (!s.control_mode)
                begin
                    if (pressed[BTN_LEFT])
                    begin
                        s.second_player = 1'b0;
                        s.meta_consumed = 1'b1;
                    end
                    else if (pressed[BTN_RIGHT])
                    begin
                        s.second_player = 1'b1;
                        s.meta_consumed = 1'b1;
                    end
                end
            end

            // An unused meta tap reports a release.
            if (s.meta_consumed)
            begin
                if (!meta)
                begin
                    s.meta_consumed    = 1'b0;
                    s.meta_held_before = 1'b0;
                end
            end
            else if (!meta && s.meta_held_before)
            begin
                s.meta_held_before = 1'b0;
                released           = 1'b1;
            end

            if (s.control_mode)
            begin
                if (!meta)
                begin
                    kb = asre_directions(pressed, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT);
                    kb[KEY_ENTER]  = pressed[BTN_LP];
                    kb[KEY_ESCAPE] = pressed[BTN_MP];
                    kb[KEY_F2]     = pressed[BTN_LK];
                    kb[KEY_F3]     = pressed[BTN_MK];
                    kb[KEY_TAB]    = released;
                    kb[KEY_9]      = pressed[BTN_SELECT];
                    if (cfg.bonus_buttons)
                    begin
                        cons[CONS_VOL_UP]   = pressed[BTN_4P];
                        cons[CONS_VOL_DOWN] = pressed[BTN_4K];
                    end
                end
            end
            else if (!s.second_player)
            begin
                if (meta)
                begin
                    if (pressed[BTN_LK])
                    begin
                        kb[KEY_ENTER]   = 1'b1;
                        s.meta_consumed = 1'b1;
                    end
                    if (pressed[BTN_MK])
                    begin
                        kb[KEY_ESCAPE]  = 1'b1;
                        s.meta_consumed = 1'b1;
                    end
                    if (cfg.home_emulation && pressed[BTN_SELECT])
                    begin
                        kb[KEY_P]       = 1'b1;
                        s.meta_consumed = 1'b1;
                    end
                end
                else
                begin
                    kb = asre_directions(pressed, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT)
                       | asre_map_buttons(pressed, map, cfg.bonus_buttons, 1'b0);
                    kb[KEY_1] = released;
                    kb[KEY_5] = pressed[BTN_SELECT];
                    kb[KEY_P] = pressed[BTN_HOME];
                end
            end
            else if (!meta)
            begin
                kb = asre_directions(pressed, KEY_R, KEY_F, KEY_D, KEY_G)
                   | asre_map_buttons(pressed, map, cfg.bonus_buttons, 1'b1);
                kb[KEY_2] = released;
                kb[KEY_6] = pressed[BTN_SELECT];
                kb[KEY_P] = pressed[BTN_HOME];
            end

            send = (kb != state.last_report)
                || (cfg.idle_rate != 8'd0 && state.idle_count >= cfg.idle_rate);
            s.last_report = kb;
            if (send)
            begin
                s.idle_count = '0;
            end
        end

        state_next      = s;
        send_keyboard   = send;
        keyboard_report = kb;
        send_consumer   = |cons;
        consumer_report = cons;
    end

endmodule

`default_nettype wire

// File: hw/rtl/arcade_stick_keyboard_report_encoder_top.sv
// Arcade stick keyboard report encoder. Each transaction on the slave-side
// stream is either a button sample (tuser 0) or one 4 ms tick (tuser 1).
// A sample yields exactly one transaction on the master-side stream carrying
// the 32-bit keyboard key bitmap, the 2-bit consumer bitmap and their send
// flags; a tick only advances the idle counter and yields nothing. The block
// takes one transaction per clock cycle unless a sample is held back by the
// output register. A sample is registered at the input, encoded by a single
// pass of bit logic against the mode state and then moves into the output
// register, from which its result is presented on the master-side stream.
// Ticks leave the input register in the next cycle even when the output is
// stalled; a sample waits there only while the output register is full and
// not being taken. Configuration writes on the cfg channel are always taken
// and should only be issued while no sample is in flight.
`default_nettype none

module arcade_stick_keyboard_report_encoder_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,    // [14:0] pressed, [15] zero fill
    input  wire logic        s_axis_tuser,    // [0] kind

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,    // [31:0] keyboard_report,
                                              // [33:32] consumer_report, [39:34] zero
    output logic [1:0]       m_axis_tuser,    // [0] send_keyboard, [1] send_consumer

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import asre_pkg::*;

    asre_cfg_t   cfg;
    asre_state_t state_reg;
    asre_state_t state_next;

    logic                 in_valid_reg;
    logic                 in_kind_reg;
    logic [PRESSED_W-1:0] in_pressed_reg;

    logic                 out_valid_reg;
    logic                 out_send_kb_reg;
    logic [REPORT_W-1:0]  out_kb_reg;
    logic                 out_send_cons_reg;
    logic [CONS_W-1:0]    out_cons_reg;

    logic                 enc_send_kb;
    logic [REPORT_W-1:0]  enc_kb;
    logic                 enc_send_cons;
    logic [CONS_W-1:0]    enc_cons;

    logic                 advance;

    asre_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    asre_encoder u_encoder
    (
        .kind            (in_kind_reg),
        .pressed         (in_pressed_reg),
        .cfg             (cfg),
        .state           (state_reg),
        .state_next      (state_next),
        .send_keyboard   (enc_send_kb),
        .keyboard_report (enc_kb),
        .send_consumer   (enc_send_cons),
        .consumer_report (enc_cons)
    );

    // The held item moves on when it is a tick, or when the output register
    // is free or being emptied in this cycle.
    assign advance = in_valid_reg
                  && (in_kind_reg == KIND_TICK || !out_valid_reg || m_axis_tready);

    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg    <= s_axis_tuser;
            in_pressed_reg <= s_axis_tdata[PRESSED_W-1:0];
        end
    end

    // Mode state, last report and idle counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_kind_reg == KIND_SAMPLE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_kind_reg == KIND_SAMPLE)
        begin
            out_send_kb_reg   <= enc_send_kb;
            out_kb_reg        <= enc_kb;
            out_send_cons_reg <= enc_send_cons;
            out_cons_reg      <= enc_cons;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_cons_reg, out_kb_reg};
    assign m_axis_tuser  = {out_send_cons_reg, out_send_kb_reg};

    // The consumer send flag follows the consumer bitmap it travels with.
    a_cons_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_send_cons_reg == (out_cons_reg != '0)))
        else $error("send_consumer disagrees with consumer_report");

    // The top key bit is never used.
    a_kb_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !out_kb_reg[REPORT_W-1])
        else $error("keyboard report bit 31 set");

    // The up and down keys are never reported together.
    a_no_up_down: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_kb_reg[KEY_UP] && out_kb_reg[KEY_DOWN]))
        else $error("up and down keys reported together");

    // A sent keyboard report restarts the idle period.
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_SAMPLE && enc_send_kb) |=>
            (state_reg.idle_count == 8'd0))
        else $error("idle counter not cleared after a sent report");

    // The reported bitmap becomes the comparison base for the next sample.
    a_last_report: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_kind_reg == KIND_SAMPLE) |=>
            (state_reg.last_report == out_kb_reg))
        else $error("last report does not match delivered report");

endmodule

`default_nettype wire

// File: tb/arcade_stick_keyboard_report_encoder_top_test.sv
`timescale 1ns / 100ps

// Self-checking bench for the arcade stick keyboard report encoder.
//
// Button samples and 4 ms ticks go in on the slave-side stream. A behavioral
// copy of the encoder, kept in a small tracker class, follows every accepted
// transaction. For each sample it works out the keyboard and consumer report
// that the block has to return. Every transaction on the master-side stream
// is then compared field by field against the oldest report still awaited.
//
// The run has three parts:
//   - a short directed list: extremes, meta taps, mode and player switches,
//     and every layout code;
//   - randomized traffic in three idling phases, with two register settings
//     per phase. Most samples are meta gestures and play input with random
//     content, and the rest is raw noise;
//   - a long receiver hold-off. The block fills up and stalls its input while
//     the sender keeps offering transactions.
// Registers are only written once the block has drained completely.
module arcade_stick_keyboard_report_encoder_top_test;
    import asre_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int HOLD_OFF_CYCLES   = 300;
    localparam int SETTLE_CYCLES     = 8;
    localparam int ITEMS_PER_SETTING = 320;

    // Single-button masks in the pressed vector.
    localparam logic [14:0] B_UP     = 15'd1 << BTN_UP;
    localparam logic [14:0] B_DOWN   = 15'd1 << BTN_DOWN;
    localparam logic [14:0] B_LEFT   = 15'd1 << BTN_LEFT;
    localparam logic [14:0] B_RIGHT  = 15'd1 << BTN_RIGHT;
    localparam logic [14:0] B_LK     = 15'd1 << BTN_LK;
    localparam logic [14:0] B_MK     = 15'd1 << BTN_MK;
    localparam logic [14:0] B_4K     = 15'd1 << BTN_4K;
    localparam logic [14:0] B_LP     = 15'd1 << BTN_LP;
    localparam logic [14:0] B_MP     = 15'd1 << BTN_MP;
    localparam logic [14:0] B_4P     = 15'd1 << BTN_4P;
    localparam logic [14:0] B_START  = 15'd1 << BTN_START;
    localparam logic [14:0] B_SELECT = 15'd1 << BTN_SELECT;
    localparam logic [14:0] B_HOME   = 15'd1 << BTN_HOME;

    // Buttons that take part in meta combinations.
    localparam logic [14:0] GESTURE_MASK = B_UP | B_DOWN | B_LEFT | B_RIGHT | B_LP | B_LK |
                                           B_MK | B_SELECT;

    // A layout in which entry i holds code i, so codes six and seven both show up.
    localparam logic [23:0] LAYOUT_EVERY_CODE = {3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

    // Follows the encoder state and queues the report due for each sample.
    class key_report_tracker;
        typedef struct packed {
            logic        send_kb;
            logic [31:0] kb;
            logic        send_cons;
            logic [1:0]  cons;
        } key_report_t;

        logic [LAYOUT_W-1:0] layout_map[NUM_LAYOUTS];
        logic [7:0]          idle_rate;
        logic                home_emulation;
        logic                bonus_buttons;

        logic                meta_held;
        logic                meta_used;
        logic                control_mode;
        logic                player_two;
        logic [1:0]          layout_sel;
        logic [31:0]         last_kb;
        logic [7:0]          idle_count;

        logic [4:0]          p1_keys[6];
        logic [4:0]          p2_keys[6];

        key_report_t         awaited_reports[$];
        int                  mismatches;

        function new();
            for (int i = 0; i < NUM_LAYOUTS; i++)
            begin
                layout_map[i] = '1;
            end
            idle_rate      = '0;
            home_emulation = 1'b0;
            bonus_buttons  = 1'b0;
            meta_held      = 1'b0;
            meta_used      = 1'b0;
            control_mode   = 1'b0;
            player_two     = 1'b0;
            layout_sel     = '0;
            last_kb        = '0;
            idle_count     = '0;
            p1_keys        = '{KEY_LCTRL, KEY_LALT, KEY_SPACE, KEY_LSHIFT, KEY_X, KEY_Y};
            p2_keys        = '{KEY_A, KEY_S, KEY_Q, KEY_W, KEY_K, KEY_I};
            mismatches     = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [23:0] value);
            case (idx)
                REG_LAYOUT_ONE, REG_LAYOUT_TWO, REG_LAYOUT_THREE, REG_LAYOUT_FOUR:
                    layout_map[idx[1:0]] = value;
                REG_IDLE_RATE:      idle_rate      = value[7:0];
                REG_HOME_EMULATION: home_emulation = value[0];
                REG_BONUS_BUTTONS:  bonus_buttons  = value[0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return awaited_reports.size();
        endfunction

        function logic [31:0] direction_keys(logic [14:0] p, logic [4:0] k_up,
                                             logic [4:0] k_down, logic [4:0] k_left,
                                             logic [4:0] k_right);
            logic [31:0] r;
            r = '0;
            if (p[BTN_UP])
            begin
                r[k_up] = 1'b1;
            end
            else if (p[BTN_DOWN])
            begin
                r[k_down] = 1'b1;
            end
            if (p[BTN_LEFT])
            begin
                r[k_left] = 1'b1;
            end
            else if (p[BTN_RIGHT])
            begin
                r[k_right] = 1'b1;
            end
            return r;
        endfunction

        // Attack buttons LK..4P through the selected layout.
        function logic [31:0] attack_keys(logic [14:0] p, logic second);
            logic [31:0] r;
            logic [23:0] map;
            logic [2:0]  code;
            r   = '0;
            map = layout_map[layout_sel];
            for (int i = 0; i < 8; i++)
            begin
                code = map[3*i +: 3];
                if ((i == 3 || i == 7) && !bonus_buttons)
                begin
                    continue;
                end
                if (p[BTN_LK + i] && code < MAP_FIRST_NONE)
                begin
                    r[second ? p2_keys[code] : p1_keys[code]] = 1'b1;
                end
            end
            return r;
        endfunction

        function void log_input(logic kind, logic [14:0] p);
            logic        meta;
            logic        released;
            logic [31:0] kb;
            logic [1:0]  cons;
            key_report_t rep;

            if (kind == KIND_TICK)
            begin
                if (idle_count != IDLE_MAX)
                begin
                    idle_count++;
                end
                return;
            end

            meta     = p[BTN_START];
            released = 1'b0;
            kb       = '0;
            cons     = '0;

            if (meta)
            begin
                meta_held = 1'b1;
                if (p[BTN_LP])
                begin
                    if (p[BTN_UP])
                    begin
                        layout_sel = 2'd0;
                        meta_used  = 1'b1;
                    end
                    else if (p[BTN_RIGHT])
                    begin
                        layout_sel = 2'd1;
                        meta_used  = 1'b1;
                    end
                    else if (p[BTN_DOWN])
                    begin
                        layout_sel = 2'd2;
                        meta_used  = 1'b1;
                    end
                    else if (p[BTN_LEFT])
                    begin
                        layout_sel = 2'd3;
                        meta_used  = 1'b1;
                    end
                end
                else if (p[BTN_UP])
                begin
                    control_mode = 1'b0;
                    meta_used    = 1'b1;
                end
                else if (p[BTN_DOWN])
                begin
                    control_mode = 1'b1;
                    meta_used    = 1'b1;
                end
                if (!control_mode)
                begin
                    if (p[BTN_LEFT])
                    begin
                        player_two = 1'b0;
                        meta_used  = 1'b1;
                    end
                    else if (p[BTN_RIGHT])
                    begin
                        player_two = 1'b1;
                        meta_used  = 1'b1;
                    end
                end
            end

            if (meta_used)
            begin
                if (!meta)
                begin
                    meta_used = 1'b0;
                    meta_held = 1'b0;
                end
            end
            else if (!meta && meta_held)
            begin
                meta_held = 1'b0;
                released  = 1'b1;
            end

            if (control_mode)
            begin
                if (!meta)
                begin
                    kb = direction_keys(p, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT);
                    kb[KEY_ENTER]  = p[BTN_LP];
                    kb[KEY_ESCAPE] = p[BTN_MP];
                    kb[KEY_F2]     = p[BTN_LK];
                    kb[KEY_F3]     = p[BTN_MK];
                    kb[KEY_TAB]    = released;
                    kb[KEY_9]      = p[BTN_SELECT];
                    if (bonus_buttons)
                    begin
                        cons[CONS_VOL_UP]   = p[BTN_4P];
                        cons[CONS_VOL_DOWN] = p[BTN_4K];
                    end
                end
            end
            else if (!player_two)
            begin
                if (meta)
                begin
                    if (p[BTN_LK])
                    begin
                        kb[KEY_ENTER] = 1'b1;
                        meta_used     = 1'b1;
                    end
                    if (p[BTN_MK])
                    begin
                        kb[KEY_ESCAPE] = 1'b1;
                        meta_used      = 1'b1;
                    end
                    if (home_emulation && p[BTN_SELECT])
                    begin
                        kb[KEY_P] = 1'b1;
                        meta_used = 1'b1;
                    end
                end
                else
                begin
                    kb = direction_keys(p, KEY_UP, KEY_DOWN, KEY_LEFT, KEY_RIGHT) |
                         attack_keys(p, 1'b0);
                    kb[KEY_1] = released;
                    kb[KEY_5] = p[BTN_SELECT];
                    kb[KEY_P] = p[BTN_HOME];
                end
            end
            else if (!meta)
            begin
                kb = direction_keys(p, KEY_R, KEY_F, KEY_D, KEY_G) | attack_keys(p, 1'b1);
                kb[KEY_2] = released;
                kb[KEY_6] = p[BTN_SELECT];
                kb[KEY_P] = p[BTN_HOME];
            end

            rep.send_kb   = (kb != last_kb) || (idle_rate != 0 && idle_count >= idle_rate);
            rep.kb        = kb;
            rep.send_cons = (cons != 0);
            rep.cons      = cons;
            last_kb       = kb;
            if (rep.send_kb)
            begin
                idle_count = '0;
            end
            awaited_reports.push_back(rep);
        endfunction

        function void match_report(logic [39:0] data, logic [1:0] user);
            key_report_t want;
            if (awaited_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected report: send_kb=%0d kb=%08h send_cons=%0d cons=%0d",
                             user[0], data[31:0], user[1], data[33:32]);
                end
                return;
            end
            want = awaited_reports.pop_front();
            if (user[0] !== want.send_kb || data[31:0] !== want.kb ||
                user[1] !== want.send_cons || data[33:32] !== want.cons)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("report mismatch: expected send_kb=%0d kb=%08h send_cons=%0d cons=%0d",
                             want.send_kb, want.kb, want.send_cons, want.cons);
                    $display("                 actual   send_kb=%0d kb=%08h send_cons=%0d cons=%0d",
                             user[0], data[31:0], user[1], data[33:32]);
                end
            end
        endfunction
    endclass

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata   = '0;
    logic        s_axis_tuser   = KIND_SAMPLE;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index      = REG_LAYOUT_ONE;
    logic [23:0] cfg_data       = '0;

    key_report_tracker tracker = new();

    // The sender and the receiver each idle for this share of cycles, in percent.
    int          send_idle_pct   = 0;
    int          recv_idle_pct   = 0;
    logic        hold_off_request = 1'b0;
    int          hold_off_left   = 0;
    int          items_sent      = 0;
    int          cycle_count     = 0;
    logic [14:0] last_pressed    = '0;

    arcade_stick_keyboard_report_encoder_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The run gives up if it hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Every transaction is observed at the rising edge, where all inputs are
    // stable since they only move at the falling edge. A result is checked
    // before a same-edge input is logged: with the block's latency it can never
    // belong to that input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.match_report(m_axis_tdata, m_axis_tuser);
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.log_input(s_axis_tuser, s_axis_tdata[14:0]);
            end
            if (cfg_valid && cfg_ready)
            begin
                tracker.set_register(cfg_index, cfg_data);
            end
        end
    end

    // Receiver: random back-pressure. On request it holds off for a long
    // stretch, counted here, so that the block fills up and stalls its input.
    always @(negedge clk)
    begin
        if (hold_off_request)
        begin
            hold_off_left    = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [14:0] sparse_buttons(input int pct);
        logic [14:0] r;
        for (int i = 0; i < 15; i++)
        begin
            r[i] = ($urandom_range(99) < pct);
        end
        return r;
    endfunction

    // Offers one transaction, with a random gap in front of it, and returns at
    // the falling edge after acceptance. tvalid stays high, so that a
    // back-to-back transaction needs no extra assignment.
    task automatic push_item(input logic kind, input logic [14:0] pressed);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {1'b0, pressed};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        if (kind == KIND_SAMPLE)
        begin
            last_pressed = pressed;
        end
        items_sent++;
    endtask

    // Stops offering input and waits until every awaited report has come back.
    // A settling wait then lets a trailing tick leave the pipeline.
    task automatic drain_reports();
        s_axis_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input logic [23:0] map_one, input logic [23:0] map_two,
                                 input logic [23:0] map_three, input logic [23:0] map_four,
                                 input logic [7:0] idle, input logic home,
                                 input logic extra);
        cfg_write(REG_LAYOUT_ONE, map_one);
        cfg_write(REG_LAYOUT_TWO, map_two);
        cfg_write(REG_LAYOUT_THREE, map_three);
        cfg_write(REG_LAYOUT_FOUR, map_four);
        cfg_write(REG_IDLE_RATE, {16'd0, idle});
        cfg_write(REG_HOME_EMULATION, {23'd0, home});
        cfg_write(REG_BONUS_BUTTONS, {23'd0, extra});
        cfg_valid <= 1'b0;
    endtask

    // Random traffic. Meta gestures are a press with a combination, sometimes
    // held, then a release with play input. Repeated samples exercise the
    // unchanged-report and idle-resend paths, and raw values cover every bit.
    task automatic random_items(input int count);
        int          stop_at;
        int          pick;
        logic [14:0] combo;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 25)
            begin
                push_item(KIND_TICK, 15'($urandom));
            end
            else if (pick < 45)
            begin
                combo = B_START | (sparse_buttons(20) & GESTURE_MASK);
                push_item(KIND_SAMPLE, combo);
                if ($urandom_range(1) == 1)
                begin
                    push_item(KIND_SAMPLE, combo);
                end
                push_item(KIND_SAMPLE, sparse_buttons(15) & ~B_START);
            end
            else if (pick < 65)
            begin
                push_item(KIND_SAMPLE, last_pressed);
            end
            else if (pick < 75)
            begin
                push_item(KIND_SAMPLE, 15'($urandom));
            end
            else
            begin
                push_item(KIND_SAMPLE, sparse_buttons(18) & ~B_START);
            end
        end
    endtask

    initial
    begin
        logic [23:0] maps[4];
        logic [7:0]  idle;
        int          setting;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 19;
        recv_idle_pct = 87;

        // Directed part under the reset register values: no layout mapped,
        // no idle resend, no home emulation, no extra buttons.
        push_item(KIND_SAMPLE, '0);
        push_item(KIND_SAMPLE, '1);
        push_item(KIND_SAMPLE, '0);
        // Opposite directions at once: up beats down, left beats right.
        push_item(KIND_SAMPLE, B_UP | B_DOWN | B_LEFT | B_RIGHT);
        // A meta tap released unused sends the '1' key.
        push_item(KIND_SAMPLE, B_START);
        push_item(KIND_SAMPLE, '0);
        // Meta plus down enters control mode.
        push_item(KIND_SAMPLE, B_START | B_DOWN);
        push_item(KIND_SAMPLE, '0);
        push_item(KIND_SAMPLE, B_UP | B_LP | B_MP | B_LK | B_MK | B_SELECT | B_4K | B_4P);
        // In control mode a meta tap sends tab.
        push_item(KIND_SAMPLE, B_START);
        push_item(KIND_SAMPLE, '0);
        // Back to player mode, then over to player two.
        push_item(KIND_SAMPLE, B_START | B_UP);
        push_item(KIND_SAMPLE, B_START | B_RIGHT);
        push_item(KIND_SAMPLE, '0);
        push_item(KIND_SAMPLE, B_DOWN | B_RIGHT | B_SELECT | B_HOME);
        // Meta held as player two reports nothing, and its tap sends '2'.
        push_item(KIND_SAMPLE, B_START);
        push_item(KIND_SAMPLE, '0);
        // Player one again, and the meta shortcuts for enter and escape.
        push_item(KIND_SAMPLE, B_START | B_LEFT);
        push_item(KIND_SAMPLE, B_START | B_LK | B_MK | B_SELECT);
        push_item(KIND_SAMPLE, B_HOME);
        drain_reports();

        // Every layout code, idle resend after a single tick, home emulation
        // and the volume buttons.
        apply_setting(LAYOUT_EVERY_CODE, 24'h000000, 24'hFFFFFF, 24'($urandom), 8'd1,
                      1'b1, 1'b1);
        push_item(KIND_SAMPLE, 15'h0FF0);
        push_item(KIND_SAMPLE, B_START | B_SELECT);
        push_item(KIND_SAMPLE, '0);
        push_item(KIND_TICK, '0);
        push_item(KIND_SAMPLE, '0);
        push_item(KIND_SAMPLE, B_START | B_DOWN);
        push_item(KIND_SAMPLE, B_4K | B_4P);
        // Layout switch while in control mode leaves the player untouched.
        push_item(KIND_SAMPLE, B_START | B_LP | B_RIGHT);
        push_item(KIND_SAMPLE, B_START | B_UP);
        push_item(KIND_SAMPLE, '0);

        // Three idling phases with two register settings each.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 19;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 19;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int part = 0; part < 2; part++)
            begin
                setting = phase * 2 + part;
                for (int i = 0; i < 4; i++)
                begin
                    case ($urandom_range(3))
                        0:       maps[i] = 24'h000000;
                        1:       maps[i] = 24'hFFFFFF;
                        default: maps[i] = 24'($urandom);
                    endcase
                    if (setting == 1)
                    begin
                        maps[i] = 24'h000000;
                    end
                end
                case (setting % 4)
                    0:       idle = 8'd0;
                    1:       idle = 8'd1;
                    2:       idle = IDLE_MAX;
                    default: idle = 8'($urandom_range(12, 2));
                endcase
                // Let the block drain completely before the registers change.
                drain_reports();
                apply_setting(maps[0], maps[1], maps[2], maps[3], idle, setting[0],
                              setting[1]);

                // Let the idle counter reach the rate, one past it so that the
                // counter saturates at the top rate, then resend an unchanged
                // report.
                if (idle != 0)
                begin
                    repeat (int'(idle) + 1) push_item(KIND_TICK, 15'($urandom));
                    push_item(KIND_SAMPLE, last_pressed);
                    push_item(KIND_SAMPLE, last_pressed);
                end

                if (phase == 2 && part == 0)
                begin
                    // The receiver goes quiet while the sender keeps offering
                    // transactions, until the input side stalls.
                    hold_off_request = 1'b1;
                    random_items(60);
                end

                random_items(ITEMS_PER_SETTING);
            end
        end

        drain_reports();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/asre_pkg.sv
hw/rtl/asre_cfg_regs.sv
hw/rtl/asre_encoder.sv
hw/rtl/arcade_stick_keyboard_report_encoder_top.sv
tb/arcade_stick_keyboard_report_encoder_top_test.sv
